@@ hdl/gpiorb_pkg.sv @@
// gpiorb_pkg: request codes, register offsets and transaction structs
// for the gpio register block; no dependencies
package gpiorb_pkg;

  localparam int unsigned NumPins  = 32;
  localparam int unsigned OfsWidth = 5;
  localparam int unsigned PinWidth = 5;

  // request codes
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_EVENT = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_e;

  // register byte offsets
  localparam logic [OfsWidth-1:0] OFS_DIR   = 5'h00;
  localparam logic [OfsWidth-1:0] OFS_OUT   = 5'h04;
  localparam logic [OfsWidth-1:0] OFS_IN    = 5'h08;
  localparam logic [OfsWidth-1:0] OFS_IEN   = 5'h0C;
  localparam logic [OfsWidth-1:0] OFS_ISTAT = 5'h10;

  typedef struct packed {
    req_type_e             req_type;
    logic [OfsWidth-1:0]   reg_offset;
    logic [NumPins-1:0]    wdata;
    logic [PinWidth-1:0]   pin_index;
  } req_t;

  typedef struct packed {
    logic [NumPins-1:0] rdata;
    logic               write_rejected;
    logic               irq_pending;
  } rsp_t;

endpackage

@@ hdl/gpiorb_if.sv @@
// gpiorb_req_if / gpiorb_rsp_if: valid/ready channels of the gpio block
// no dependencies
interface gpiorb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  reg_offset;
  logic [31:0] wdata;
  logic [4:0]  pin_index;

  modport source (output valid, req_type, reg_offset, wdata, pin_index, input ready);
  modport sink   (input valid, req_type, reg_offset, wdata, pin_index, output ready);
endinterface

interface gpiorb_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic        write_rejected;
  logic        irq_pending;

  modport source (output valid, rdata, write_rejected, irq_pending, input ready);
  modport sink   (input valid, rdata, write_rejected, irq_pending, output ready);
endinterface

@@ hdl/gpio_register_block_core.sv @@
// Each transaction (bus read, bus write, pin event or nop) passes an input
// register, the register-file logic and a result register, so a
// transaction is accepted every cycle while input ready is high, and its
// result is presented from the result register; the register file updates as the transaction
// leaves the input register. Input ready drops only while the result
// register holds an untaken result and the input register is full.
// depends on gpiorb_pkg, gpiorb_if and gpiorb_regs
module gpio_register_block_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  gpiorb_req_if.sink    req_i,
  gpiorb_rsp_if.source  rsp_o
);
  import gpiorb_pkg::*;

  logic  in_valid_q;
  req_t  in_req_q;
  logic  out_valid_q;
  rsp_t  out_rsp_q;
  rsp_t  rsp;
  logic  out_adv;
  logic  in_adv;
  logic  in_fire;

  assign out_adv     = !out_valid_q || rsp_o.ready;
  assign in_adv      = in_valid_q && out_adv;
  assign req_i.ready = !in_valid_q || out_adv;
  assign in_fire     = req_i.valid && req_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_req_q.req_type   <= req_type_e'(req_i.req_type);
      in_req_q.reg_offset <= req_i.reg_offset;
      in_req_q.wdata      <= req_i.wdata;
      in_req_q.pin_index  <= req_i.pin_index;
    end
  end

  gpiorb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_adv),
    .req_i  (in_req_q),
    .rsp_o  (rsp)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      out_rsp_q <= rsp;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.rdata          = out_rsp_q.rdata;
  assign rsp_o.write_rejected = out_rsp_q.write_rejected;
  assign rsp_o.irq_pending    = out_rsp_q.irq_pending;

endmodule

@@ hdl/gpiorb_regs.sv @@
// gpiorb_regs: gpio register file with read, write, pin event and irq logic
// depends on gpiorb_pkg
module gpiorb_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  gpiorb_pkg::req_t  req_i,
  output gpiorb_pkg::rsp_t  rsp_o
);
  import gpiorb_pkg::*;

  logic [NumPins-1:0] dir_q, dir_d;
  logic [NumPins-1:0] out_q, out_d;
  logic [NumPins-1:0] in_q, in_d;
  logic [NumPins-1:0] ien_q, ien_d;
  logic [NumPins-1:0] istat_q, istat_d;
  logic [NumPins-1:0] evt_bit;
  logic [NumPins-1:0] rdata;
  logic               rejected;

  assign evt_bit = {{(NumPins-1){1'b0}}, 1'b1} << req_i.pin_index;

  // next state and response for the current transaction
  always_comb begin
    dir_d    = dir_q;
    out_d    = out_q;
    in_d     = in_q;
    ien_d    = ien_q;
    istat_d  = istat_q;
    rdata    = '0;
    rejected = 1'b0;
    unique case (req_i.req_type)
      REQ_READ: begin
        unique case (req_i.reg_offset)
          OFS_DIR:   rdata = dir_q;
          OFS_OUT:   rdata = out_q;
          OFS_IN:    rdata = in_q;
          OFS_IEN:   rdata = ien_q;
          OFS_ISTAT: rdata = istat_q;
          default:   rdata = '0;
        endcase
      end
      REQ_WRITE: begin
        unique case (req_i.reg_offset)
          OFS_DIR: dir_d = req_i.wdata;
          OFS_OUT: begin
            // setting a bit of an input pin drops the whole write
            if ((~dir_q & req_i.wdata) != '0) begin
              rejected = 1'b1;
            end else begin
              out_d = req_i.wdata;
            end
          end
          OFS_IEN:   ien_d   = req_i.wdata;
          OFS_ISTAT: istat_d = istat_q & ~req_i.wdata;
          default:   ;
        endcase
      end
      REQ_EVENT: begin
        // output pins ignore external events
        if ((dir_q & evt_bit) == '0) begin
          in_d    = (req_i.wdata != '0) ? (in_q | evt_bit) : (in_q & ~evt_bit);
          istat_d = istat_q | ((in_q ^ in_d) & ien_q);
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.rdata          = rdata;
  assign rsp_o.write_rejected = rejected;
  assign rsp_o.irq_pending    = (istat_d != '0);

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= '0;
      out_q   <= '0;
      in_q    <= '0;
      ien_q   <= '0;
      istat_q <= '0;
    end else if (en_i) begin
      dir_q   <= dir_d;
      out_q   <= out_d;
      in_q    <= in_d;
      ien_q   <= ien_d;
      istat_q <= istat_d;
    end
  end

endmodule

@@ hdl/gpiorb_checker.sv @@
// gpiorb_checker: port-level assertions for gpio_register_block_core,
// attached by bind; no dependencies
module gpiorb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] rdata_i,
  input logic        write_rejected_i,
  input logic        irq_pending_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rdata_i)
      && $stable(write_rejected_i) && $stable(irq_pending_i))
    else $error("stalled result changed");

  // a rejected write never carries read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && write_rejected_i |-> rdata_i == 32'd0)
    else $error("rejected write with nonzero rdata");

  // input backpressure only comes from a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  // an accepted transaction with a free pipeline yields a result from the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> ##1 out_valid_i)
    else $error("accepted transaction produced no result");

endmodule

bind gpio_register_block_core gpiorb_checker u_gpiorb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .rdata_i          (rsp_o.rdata),
  .write_rejected_i (rsp_o.write_rejected),
  .irq_pending_i    (rsp_o.irq_pending)
);
